// ===== rtl/hrd_pkg.sv =====
package hrd_pkg;

  localparam int LEN_BITS = 16;
  localparam int DECL_W = 16;
  localparam int HDR_LEN = 11;
  localparam int MATCH_W = $clog2(HDR_LEN + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic CMD_ARM = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic       is_arm;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] rx_byte;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              out_last;
    logic [DECL_W-1:0] declared_length;
    logic [1:0]        phase;
    logic              length_overflow;
  } result_t;

  function automatic logic [7:0] hdr_char(input logic [MATCH_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      MATCH_W'(0):  c = 8'h2B;
      MATCH_W'(1):  c = 8'h48;
      MATCH_W'(2):  c = 8'h54;
      MATCH_W'(3):  c = 8'h54;
      MATCH_W'(4):  c = 8'h50;
      MATCH_W'(5):  c = 8'h52;
      MATCH_W'(6):  c = 8'h45;
      MATCH_W'(7):  c = 8'h41;
      MATCH_W'(8):  c = 8'h44;
      MATCH_W'(9):  c = 8'h3A;
      MATCH_W'(10): c = 8'h20;
      default:      c = 8'h2B;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hrd_if.sv =====
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface hrd_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                out_byte;
  logic                      out_valid;
  logic                      out_last;
  logic [hrd_pkg::DECL_W-1:0] declared_length;
  logic [1:0]                phase;
  logic                      length_overflow;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output declared_length, output phase, output length_overflow,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                input declared_length, input phase, input length_overflow,
                output ready);
endinterface

// ===== rtl/hrd_front.sv =====
module hrd_front (
  hrd_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output hrd_pkg::q_entry_t  push_entry
);

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;

  always_comb begin
    push_entry.is_arm = (in_ch.command == hrd_pkg::CMD_ARM);
    push_entry.is_cr = (in_ch.rx_byte == hrd_pkg::CH_CR);
    push_entry.is_lf = (in_ch.rx_byte == hrd_pkg::CH_LF);
    push_entry.is_digit = (in_ch.rx_byte >= hrd_pkg::CH_ZERO) &&
                          (in_ch.rx_byte <= hrd_pkg::CH_NINE);
    push_entry.digit = in_ch.rx_byte[3:0];
    push_entry.rx_byte = in_ch.rx_byte;
  end

endmodule

// ===== rtl/hrd_queue.sv =====
module hrd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hrd_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output logic               full,
  output logic               q_valid,
  output hrd_pkg::q_entry_t  q_entry
);

  hrd_pkg::q_entry_t              slot_r [hrd_pkg::QUEUE_DEPTH];
  logic [hrd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [hrd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [hrd_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_pop;

  assign full = (count_r == hrd_pkg::QCNT_W'(hrd_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = slot_r[rd_ptr_r];
  assign do_pop = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hrd_pkg::QPTR_W'(hrd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hrd_pkg::QPTR_W'(hrd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hrd_pkg::QCNT_W'(hrd_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

// ===== rtl/hrd_back.sv =====
module hrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hrd_pkg::q_entry_t  q_entry,
  output logic               pop,
  hrd_out_if.source          out_ch
);

  localparam logic [hrd_pkg::LEN_BITS-1:0] LEN_MAX = '1;
  localparam int ACC_X_W = hrd_pkg::LEN_BITS + 4;

  hrd_pkg::phase_t                 phase_r, phase_nxt;
  logic [hrd_pkg::MATCH_W-1:0]     match_r, match_nxt;
  logic [hrd_pkg::LEN_BITS-1:0]    acc_r, acc_nxt;
  logic                            ended_r, ended_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [hrd_pkg::LEN_BITS-1:0]    cnt_r, cnt_nxt;
  logic                            ovld_r;
  hrd_pkg::result_t                res_r, res_nxt;

  logic                            take;
  logic [hrd_pkg::MATCH_W-1:0]     idx;
  logic                            hdr_hit;
  logic                            hdr_done;
  logic [ACC_X_W-1:0]              acc_x10;
  logic [hrd_pkg::LEN_BITS-1:0]    cnt_inc;

  assign take = q_valid && (!ovld_r || out_ch.ready);
  assign pop = take;

  assign idx = (match_r < hrd_pkg::MATCH_W'(hrd_pkg::HDR_LEN)) ? match_r : '0;
  assign hdr_hit = (q_entry.rx_byte == hrd_pkg::hdr_char(idx));
  assign hdr_done = hdr_hit && (idx == hrd_pkg::MATCH_W'(hrd_pkg::HDR_LEN - 1));
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                   ACC_X_W'(q_entry.digit);
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (q_entry.is_arm) begin
        phase_nxt = hrd_pkg::PH_SEEK;
      end else begin
        unique case (phase_r)
          hrd_pkg::PH_IDLE: phase_nxt = hrd_pkg::PH_IDLE;
          hrd_pkg::PH_SEEK: begin
            if (hdr_done) phase_nxt = hrd_pkg::PH_LEN;
          end
          hrd_pkg::PH_LEN: begin
            if (q_entry.is_lf) begin
              phase_nxt = (acc_r == '0) ? hrd_pkg::PH_IDLE : hrd_pkg::PH_DATA;
            end
          end
          hrd_pkg::PH_DATA: begin
            if (cnt_inc == acc_r) phase_nxt = hrd_pkg::PH_IDLE;
          end
          default: phase_nxt = hrd_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    match_nxt = match_r;
    acc_nxt = acc_r;
    ended_nxt = ended_r;
    ovf_nxt = ovf_r;
    cnt_nxt = cnt_r;
    res_nxt.out_byte = 8'h00;
    res_nxt.out_valid = 1'b0;
    res_nxt.out_last = 1'b0;
    if (q_entry.is_arm) begin
      match_nxt = '0;
      acc_nxt = '0;
      ended_nxt = 1'b0;
      ovf_nxt = 1'b0;
      cnt_nxt = '0;
    end else begin
      unique case (phase_r)
        hrd_pkg::PH_IDLE: ;
        hrd_pkg::PH_SEEK: begin
          if (hdr_done) begin
            match_nxt = '0;
            acc_nxt = '0;
            ended_nxt = 1'b0;
            ovf_nxt = 1'b0;
          end else if (hdr_hit) begin
            match_nxt = idx + 1'b1;
          end else begin
            match_nxt = (q_entry.rx_byte == hrd_pkg::CH_PLUS) ?
                        hrd_pkg::MATCH_W'(1) : '0;
          end
        end
        hrd_pkg::PH_LEN: begin
          if (q_entry.is_cr) begin
            acc_nxt = acc_r;
          end else if (q_entry.is_lf) begin
            cnt_nxt = '0;
            res_nxt.out_last = (acc_r == '0);
          end else if (!ended_r) begin
            if (q_entry.is_digit) begin
              if (acc_x10 > ACC_X_W'(LEN_MAX)) begin
                acc_nxt = LEN_MAX;
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_x10[hrd_pkg::LEN_BITS-1:0];
              end
            end else begin
              ended_nxt = 1'b1;
            end
          end
        end
        hrd_pkg::PH_DATA: begin
          res_nxt.out_byte = q_entry.rx_byte;
          res_nxt.out_valid = 1'b1;
          cnt_nxt = cnt_inc;
          res_nxt.out_last = (cnt_inc == acc_r);
        end
        default: ;
      endcase
    end
    res_nxt.declared_length = hrd_pkg::DECL_W'(acc_nxt);
    res_nxt.phase = phase_nxt;
    res_nxt.length_overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrd_pkg::PH_IDLE;
      match_r <= '0;
      acc_r <= '0;
      ended_r <= 1'b0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        match_r <= match_nxt;
        acc_r <= acc_nxt;
        ended_r <= ended_nxt;
        ovf_r <= ovf_nxt;
        cnt_r <= cnt_nxt;
        ovld_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.out_byte = res_r.out_byte;
  assign out_ch.out_valid = res_r.out_valid;
  assign out_ch.out_last = res_r.out_last;
  assign out_ch.declared_length = res_r.declared_length;
  assign out_ch.phase = res_r.phase;
  assign out_ch.length_overflow = res_r.length_overflow;

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && res_r.out_last) |-> (res_r.phase == 2'(hrd_pkg::PH_IDLE)))
    else $error("last item without return to idle");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && res_r.out_valid && !res_r.out_last) |->
    (res_r.phase == 2'(hrd_pkg::PH_DATA)))
    else $error("payload byte outside payload phase");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hrd_pkg::PH_DATA) |-> (acc_r != '0))
    else $error("payload phase with zero length");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match_r < hrd_pkg::MATCH_W'(hrd_pkg::HDR_LEN))
    else $error("header match position out of range");

endmodule

// ===== rtl/http_read_response_deframer_core.sv =====
// Channel   Direction  Payload
// in_ch     sink       command, rx_byte
// out_ch    source     out_byte, out_valid, out_last, declared_length, phase,
//                      length_overflow
//
// Every accepted item yields exactly one result item, through the queue and then the result register.
// The block sustains one item per cycle while out_ch is ready; the parse state update
// in the back end is the loop that sets this rate.
// A two-entry queue separates classification from execution, and a result register
// holds each finished result on out_ch; a new item is taken only when that register is empty or out_ch is ready.
// Reset (rst_n low at a clock edge) empties the queue and returns to idle discard.
module http_read_response_deframer_core (
  input  logic       clk,
  input  logic       rst_n,
  hrd_in_if.sink     in_ch,
  hrd_out_if.source  out_ch
);

  logic               q_full;
  logic               push;
  hrd_pkg::q_entry_t  push_entry;
  logic               pop;
  logic               q_valid;
  hrd_pkg::q_entry_t  q_entry;

  hrd_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  hrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  hrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== test/http_read_response_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module http_read_response_deframer_core_tb;

  localparam int RANDOM_ITEMS = 900;
  localparam int TAIL_ITEMS = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_N = 26;
  localparam int unsigned LEN_MAX = (1 << hrd_pkg::LEN_BITS) - 1;
  localparam logic [8*hrd_pkg::HDR_LEN-1:0] HDR_TEXT = "+HTTPREAD: ";

  localparam hrd_pkg::result_t ST_IDLE =
    '{8'h00, 1'b0, 1'b0, 16'h0000, hrd_pkg::PH_IDLE, 1'b0};
  localparam hrd_pkg::result_t ST_ARMED =
    '{8'h00, 1'b0, 1'b0, 16'h0000, hrd_pkg::PH_SEEK, 1'b0};

  typedef struct packed {
    logic    cmd;
    logic [7:0] b;
    logic    typed;
    hrd_pkg::result_t want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrd_in_if  in_ch ();
  hrd_out_if out_ch ();

  http_read_response_deframer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_t            stim_q[$];
  hrd_pkg::result_t status_q[$];
  stim_t            dir_tab [DIR_N];

  hrd_pkg::phase_t              dfr_phase = hrd_pkg::PH_IDLE;
  logic [3:0]                   dfr_match = '0;
  logic [hrd_pkg::LEN_BITS-1:0] dfr_len = '0;
  logic                         dfr_digits_done = 1'b0;
  logic                         dfr_ovf = 1'b0;
  logic [hrd_pkg::LEN_BITS-1:0] dfr_count = '0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  logic        tail_calm = 1'b0;
  logic        rx_calm = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] hdr_byte(input int unsigned k);
    return HDR_TEXT[8*(hrd_pkg::HDR_LEN-1-k) +: 8];
  endfunction

  function automatic hrd_pkg::result_t deframe_step(input logic cmd, input logic [7:0] b);
    hrd_pkg::result_t r;
    int unsigned      acc;
    r = '0;
    if (cmd == hrd_pkg::CMD_ARM) begin
      dfr_phase = hrd_pkg::PH_SEEK;
      dfr_match = '0;
      dfr_len = '0;
      dfr_digits_done = 1'b0;
      dfr_ovf = 1'b0;
      dfr_count = '0;
    end else begin
      case (dfr_phase)
        hrd_pkg::PH_SEEK: begin
          if (b == hdr_byte(dfr_match)) begin
            if (dfr_match == hrd_pkg::HDR_LEN - 1) begin
              dfr_match = '0;
              dfr_phase = hrd_pkg::PH_LEN;
              dfr_len = '0;
              dfr_digits_done = 1'b0;
              dfr_ovf = 1'b0;
            end else begin
              dfr_match = dfr_match + 1'b1;
            end
          end else begin
            dfr_match = (b == hrd_pkg::CH_PLUS) ? 4'd1 : 4'd0;
          end
        end
        hrd_pkg::PH_LEN: begin
          if (b == hrd_pkg::CH_LF) begin
            dfr_count = '0;
            if (dfr_len == 0) begin
              r.out_last = 1'b1;
              dfr_phase = hrd_pkg::PH_IDLE;
            end else begin
              dfr_phase = hrd_pkg::PH_DATA;
            end
          end else if (b != hrd_pkg::CH_CR && !dfr_digits_done) begin
            if (b >= hrd_pkg::CH_ZERO && b <= hrd_pkg::CH_NINE) begin
              acc = dfr_len * 10 + (b - hrd_pkg::CH_ZERO);
              if (acc > LEN_MAX) begin
                acc = LEN_MAX;
                dfr_ovf = 1'b1;
              end
              dfr_len = acc[hrd_pkg::LEN_BITS-1:0];
            end else begin
              dfr_digits_done = 1'b1;
            end
          end
        end
        hrd_pkg::PH_DATA: begin
          r.out_byte = b;
          r.out_valid = 1'b1;
          dfr_count = dfr_count + 1'b1;
          if (dfr_count == dfr_len) begin
            r.out_last = 1'b1;
            dfr_phase = hrd_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    r.declared_length = hrd_pkg::DECL_W'(dfr_len);
    r.phase = dfr_phase;
    r.length_overflow = dfr_ovf;
    return r;
  endfunction

  task automatic push_item(input logic cmd, input logic [7:0] b);
    stim_q.push_back('{cmd, b, 1'b0, '0});
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // The length 70000 saturates, and the digit after the non-digit is ignored.
  initial begin
    int unsigned      k, n, j, r, bad, nd, plen, tmp, pay;
    int unsigned      dig [8];
    logic [7:0]       junk;
    hrd_pkg::result_t predicted;

    in_ch.valid = 1'b0;
    in_ch.command = hrd_pkg::CMD_ARM;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;

    dir_tab = '{
      '{hrd_pkg::CMD_BYTE, 8'hFF, 1'b1, ST_IDLE},
      '{hrd_pkg::CMD_ARM,  8'h00, 1'b1, ST_ARMED},
      '{hrd_pkg::CMD_BYTE, 8'h2B, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h48, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h2B, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h48, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h54, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h54, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h50, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h52, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h45, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h41, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h44, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h3A, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h20, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h37, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h30, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, hrd_pkg::CH_CR, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h30, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h30, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h30, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h78, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h35, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, hrd_pkg::CH_LF, 1'b0, '0},
      '{hrd_pkg::CMD_BYTE, 8'h00, 1'b0, '0},
      '{hrd_pkg::CMD_ARM,  8'hFF, 1'b1, ST_ARMED}
    };
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);

    while (stim_q.size() < DIR_N + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          push_item(($urandom_range(0, 3) == 0) ? hrd_pkg::CMD_ARM : hrd_pkg::CMD_BYTE,
                    8'($urandom));
      end else begin
        push_item(hrd_pkg::CMD_ARM, 8'($urandom));
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) push_item(hrd_pkg::CMD_BYTE, 8'($urandom));
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) push_item(hrd_pkg::CMD_BYTE, hdr_byte(k));
        end
        bad = ($urandom_range(0, 11) == 0) ? $urandom_range(0, hrd_pkg::HDR_LEN - 1) :
              hrd_pkg::HDR_LEN;
        for (k = 0; k < hrd_pkg::HDR_LEN; k++)
          push_item(hrd_pkg::CMD_BYTE, (k == bad) ? 8'($urandom) : hdr_byte(k));

        r = $urandom_range(0, 99);
        if (r < 12) plen = 0;
        else if (r < 80) plen = $urandom_range(1, 12);
        else if (r < 92) plen = $urandom_range(13, 40);
        else if (r < 95) plen = $urandom_range(256, 300);
        else plen = $urandom_range(60000, 999999);

        if ($urandom_range(0, 7) == 0) push_item(hrd_pkg::CMD_BYTE, hrd_pkg::CH_ZERO);
        if (plen != 0 || $urandom_range(0, 1) == 0) begin
          tmp = plen;
          nd = 0;
          do begin
            dig[nd] = tmp % 10;
            tmp = tmp / 10;
            nd++;
          end while (tmp != 0);
          for (j = nd; j > 0; j--) begin
            if ($urandom_range(0, 7) == 0) push_item(hrd_pkg::CMD_BYTE, hrd_pkg::CH_CR);
            push_item(hrd_pkg::CMD_BYTE, hrd_pkg::CH_ZERO + 8'(dig[j-1]));
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          do junk = 8'($urandom);
          while ((junk >= hrd_pkg::CH_ZERO && junk <= hrd_pkg::CH_NINE) ||
                 junk == hrd_pkg::CH_CR || junk == hrd_pkg::CH_LF);
          push_item(hrd_pkg::CMD_BYTE, junk);
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) begin
            do junk = 8'($urandom);
            while (junk == hrd_pkg::CH_LF);
            push_item(hrd_pkg::CMD_BYTE, junk);
          end
        end
        if ($urandom_range(0, 3) != 0) push_item(hrd_pkg::CMD_BYTE, hrd_pkg::CH_CR);
        push_item(hrd_pkg::CMD_BYTE, hrd_pkg::CH_LF);

        pay = (plen > 300) ? $urandom_range(0, 20) : plen;
        if (pay > 0 && $urandom_range(0, 9) == 0) pay = $urandom_range(0, pay - 1);
        for (k = 0; k < pay; k++) push_item(hrd_pkg::CMD_BYTE, 8'($urandom));
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) push_item(hrd_pkg::CMD_BYTE, 8'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < stim_q.size(); k++) begin
      if (k + TAIL_ITEMS >= stim_q.size()) tail_calm <= 1'b1;
      if (k + TAIL_ITEMS < stim_q.size() && (k / 60) % 3 != 2 && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.command <= stim_q[k].cmd;
      in_ch.rx_byte <= stim_q[k].b;
      do @(posedge clk); while (!in_ch.ready);
      predicted = deframe_step(stim_q[k].cmd, stim_q[k].b);
      status_q.push_back(stim_q[k].typed ? stim_q[k].want : predicted);
    end
    in_ch.valid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (tail_calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) rx_calm <= !rx_calm;
  end

  always @(posedge clk) begin
    hrd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual byte=%02h valid=%0b last=%0b",
                 $time, out_ch.out_byte, out_ch.out_valid, out_ch.out_last);
        mismatch_count++;
      end else begin
        want = status_q.pop_front();
        cmp_field("out_byte", want.out_byte, out_ch.out_byte);
        cmp_field("out_valid", want.out_valid, out_ch.out_valid);
        cmp_field("out_last", want.out_last, out_ch.out_last);
        cmp_field("declared_length", want.declared_length, out_ch.declared_length);
        cmp_field("phase", want.phase, out_ch.phase);
        cmp_field("length_overflow", want.length_overflow, out_ch.length_overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
